// ----- sv/cwr_pkg.sv -----
// cwr_pkg: shared types and constants for the collinear waypoint reducer
// command and status structs between controller and datapath, controller state encoding
// no dependencies
package cwr_pkg;

  // tolerance register width and its square
  localparam int unsigned TOL_BITS  = 23;
  localparam int unsigned TOL2_BITS = 2 * TOL_BITS;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_SUM,
    ST_WMUL,
    ST_WSUM,
    ST_DECIDE,
    ST_EMIT_NEW,
    ST_EMIT_PEND,
    ST_EMIT_FINAL
  } cwr_state_e;

  // source of the next result
  typedef enum logic [1:0] {
    SEL_NEW,
    SEL_PEND,
    SEL_FINAL
  } cwr_emit_sel_e;

  // controller to datapath
  typedef struct packed {
    logic          load_in;
    logic          pend_from_in;
    logic          pend_from_n;
    logic          kept_from_n;
    logic          kept_from_pend;
    logic          emit;
    cwr_emit_sel_e emit_sel;
  } cwr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic drop;
    logic out_free;
    logic n_last;
  } cwr_stat_t;

endpackage

// ----- sv/cwr_datapath.sv -----
// cwr_datapath: point registers, distance arithmetic pipeline and output register
// depends on cwr_pkg; driven by cwr_ctrl through cwr_cmd_t
module cwr_datapath #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cwr_pkg::cwr_cmd_t             cmd_i,
  output cwr_pkg::cwr_stat_t            stat_o,
  input  logic                          cfg_we_i,
  input  logic [cwr_pkg::TOL_BITS-1:0]  cfg_wdata_i,
  input  logic signed [COORD_BITS-1:0]  point_x_i,
  input  logic signed [COORD_BITS-1:0]  point_y_i,
  input  logic                          path_last_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic signed [COORD_BITS-1:0]  out_x_o,
  output logic signed [COORD_BITS-1:0]  out_y_o,
  output logic                          point_valid_o,
  output logic                          path_end_o
);
  import cwr_pkg::*;

  localparam int unsigned W   = COORD_BITS;
  localparam int unsigned D   = W + 1;           // signed difference
  localparam int unsigned P   = 2 * D;           // signed product
  localparam int unsigned M   = 2 * D - 1;       // magnitude of a sum of products
  localparam int unsigned H   = M - D;           // high part of a magnitude split
  localparam int unsigned TB  = TOL_BITS;
  localparam int unsigned T2  = TOL2_BITS;
  localparam int unsigned PHH = 2 * H;
  localparam int unsigned PHL = H + D;
  localparam int unsigned PLL = 2 * D;
  localparam int unsigned PTH = TB + H;
  localparam int unsigned PTL = TB + D;
  localparam int unsigned CW  = (2 * M > T2 + M) ? 2 * M : T2 + M;

  // tolerance register
  logic [TB-1:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // incoming, kept and pending points
  logic signed [W-1:0] n_x_q, n_y_q, kept_x_q, kept_y_q, pend_x_q, pend_y_q;
  logic                n_last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      n_x_q    <= point_x_i;
      n_y_q    <= point_y_i;
      n_last_q <= path_last_i;
    end
    if (cmd_i.kept_from_n) begin
      kept_x_q <= n_x_q;
      kept_y_q <= n_y_q;
    end else if (cmd_i.kept_from_pend) begin
      kept_x_q <= pend_x_q;
      kept_y_q <= pend_y_q;
    end
    if (cmd_i.pend_from_in) begin
      pend_x_q <= point_x_i;
      pend_y_q <= point_y_i;
    end else if (cmd_i.pend_from_n) begin
      pend_x_q <= n_x_q;
      pend_y_q <= n_y_q;
    end
  end

  // arithmetic pipeline: the point registers hold still while an item is in work,
  // so the stages load every cycle and the controller only counts them off

  // stage 1: segment and offset vectors relative to the kept point
  logic signed [D-1:0] sx_q, sy_q, rx_q, ry_q;

  always_ff @(posedge clk_i) begin
    sx_q <= D'(n_x_q) - D'(kept_x_q);
    sy_q <= D'(n_y_q) - D'(kept_y_q);
    rx_q <= D'(pend_x_q) - D'(kept_x_q);
    ry_q <= D'(pend_y_q) - D'(kept_y_q);
  end

  // stage 2: pairwise products and tolerance squared
  logic signed [P-1:0] p_sxsx_q, p_sysy_q, p_rxsx_q, p_rysy_q;
  logic signed [P-1:0] p_rxsy_q, p_rysx_q, p_rxrx_q, p_ryry_q;
  logic [T2-1:0]       tol2_q;
  logic                degen_q;

  always_ff @(posedge clk_i) begin
    p_sxsx_q <= P'(sx_q) * P'(sx_q);
    p_sysy_q <= P'(sy_q) * P'(sy_q);
    p_rxsx_q <= P'(rx_q) * P'(sx_q);
    p_rysy_q <= P'(ry_q) * P'(sy_q);
    p_rxsy_q <= P'(rx_q) * P'(sy_q);
    p_rysx_q <= P'(ry_q) * P'(sx_q);
    p_rxrx_q <= P'(rx_q) * P'(rx_q);
    p_ryry_q <= P'(ry_q) * P'(ry_q);
    tol2_q   <= T2'(tol_q) * T2'(tol_q);
    degen_q  <= (sx_q == '0) && (sy_q == '0);
  end

  // stage 3: squared length, projection, |cross| and squared offset
  logic signed [P-1:0] len2_sum, d2_sum, cross_diff;
  logic [M-1:0]        len2_q, d2_q, cross_mag_q;
  logic signed [P-1:0] proj_q;

  always_comb begin
    len2_sum   = p_sxsx_q + p_sysy_q;
    d2_sum     = p_rxrx_q + p_ryry_q;
    cross_diff = (p_rxsy_q >= p_rysx_q) ? (p_rxsy_q - p_rysx_q) : (p_rysx_q - p_rxsy_q);
  end

  always_ff @(posedge clk_i) begin
    len2_q      <= len2_sum[M-1:0];
    d2_q        <= d2_sum[M-1:0];
    cross_mag_q <= cross_diff[M-1:0];
    proj_q      <= p_rxsx_q + p_rysy_q;
  end

  // stage 4: partial products of cross^2 and tol^2 * len^2, side conditions
  logic [H-1:0]   ch, lh;
  logic [D-1:0]   cl, ll;
  logic [TB-1:0]  th, tl;
  logic [PHH-1:0] chch_q;
  logic [PHL-1:0] chcl_q;
  logic [PLL-1:0] clcl_q;
  logic [PTH-1:0] thlh_q, tllh_q;
  logic [PTL-1:0] thll_q, tlll_q;
  logic           proj_ok_q, d2_ok_q;

  always_comb begin
    ch = cross_mag_q[M-1:D];
    cl = cross_mag_q[D-1:0];
    lh = len2_q[M-1:D];
    ll = len2_q[D-1:0];
    th = tol2_q[T2-1:TB];
    tl = tol2_q[TB-1:0];
  end

  always_ff @(posedge clk_i) begin
    chch_q    <= PHH'(ch) * PHH'(ch);
    chcl_q    <= PHL'(ch) * PHL'(cl);
    clcl_q    <= PLL'(cl) * PLL'(cl);
    thlh_q    <= PTH'(th) * PTH'(lh);
    thll_q    <= PTL'(th) * PTL'(ll);
    tllh_q    <= PTH'(tl) * PTH'(lh);
    tlll_q    <= PTL'(tl) * PTL'(ll);
    proj_ok_q <= !proj_q[P-1] && (proj_q[M-1:0] <= len2_q);
    d2_ok_q   <= CW'(d2_q) <= CW'(tol2_q);
  end

  // stage 5: assemble the two wide sides
  logic [CW-1:0] c2_q, rhs_q;

  always_ff @(posedge clk_i) begin
    c2_q  <= (CW'(chch_q) << PLL) + (CW'(chcl_q) << (D + 1)) + CW'(clcl_q);
    rhs_q <= (CW'(thlh_q) << (TB + D)) + (CW'(thll_q) << TB)
           + (CW'(tllh_q) << D) + CW'(tlll_q);
  end

  // drop decision, read by the controller in its decide state
  logic drop;

  assign drop = degen_q ? d2_ok_q : (proj_ok_q && (c2_q <= rhs_q));

  // output register
  logic                out_valid_q, point_valid_q, path_end_q;
  logic signed [W-1:0] out_x_q, out_y_q;
  logic                out_free;
  logic                n_eq_kept;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign n_eq_kept = (n_x_q == kept_x_q) && (n_y_q == kept_y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      case (cmd_i.emit_sel)
        SEL_NEW: begin
          out_x_q       <= n_x_q;
          out_y_q       <= n_y_q;
          point_valid_q <= 1'b1;
          path_end_q    <= n_last_q;
        end
        SEL_PEND: begin
          out_x_q       <= pend_x_q;
          out_y_q       <= pend_y_q;
          point_valid_q <= 1'b1;
          path_end_q    <= 1'b0;
        end
        SEL_FINAL: begin
          // final point repeating the kept point closes the path with no point
          out_x_q       <= n_eq_kept ? '0 : n_x_q;
          out_y_q       <= n_eq_kept ? '0 : n_y_q;
          point_valid_q <= !n_eq_kept;
          path_end_q    <= 1'b1;
        end
        default: begin
          out_x_q       <= '0;
          out_y_q       <= '0;
          point_valid_q <= 1'b0;
          path_end_q    <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign point_valid_o = point_valid_q;
  assign path_end_o    = path_end_q;

  assign stat_o.drop     = drop;
  assign stat_o.out_free = out_free;
  assign stat_o.n_last   = n_last_q;

endmodule

// ----- sv/cwr_ctrl.sv -----
// cwr_ctrl: sequencing state machine for the waypoint reducer
// depends on cwr_pkg; commands cwr_datapath through cwr_cmd_t
module cwr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               path_last_i,
  output logic               in_stall_o,
  input  cwr_pkg::cwr_stat_t stat_i,
  output cwr_pkg::cwr_cmd_t  cmd_o
);
  import cwr_pkg::*;

  // points seen in the current path, saturating at two
  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_TWO  = 2'd2;

  cwr_state_e state_q, state_d;
  logic [1:0] seen_q, seen_d;
  logic       accept;

  assign accept = (state_q == ST_IDLE) && in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seen_q  <= SEEN_NONE;
    end else begin
      state_q <= state_d;
      seen_q  <= seen_d;
    end
  end

  // next state and path position
  always_comb begin
    state_d = state_q;
    seen_d  = seen_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (seen_q)
            SEEN_NONE: state_d = ST_EMIT_NEW;
            SEEN_ONE: begin
              if (path_last_i) begin
                state_d = ST_EMIT_NEW;
              end else begin
                seen_d = SEEN_TWO;
              end
            end
            default: state_d = ST_DIFF;
          endcase
        end
      end
      ST_DIFF:   state_d = ST_MUL;
      ST_MUL:    state_d = ST_SUM;
      ST_SUM:    state_d = ST_WMUL;
      ST_WMUL:   state_d = ST_WSUM;
      ST_WSUM:   state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (!stat_i.drop) begin
          state_d = ST_EMIT_PEND;
        end else if (stat_i.n_last) begin
          state_d = ST_EMIT_FINAL;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT_NEW: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
          seen_d  = stat_i.n_last ? SEEN_NONE : SEEN_ONE;
        end
      end
      ST_EMIT_PEND: begin
        if (stat_i.out_free) begin
          state_d = stat_i.n_last ? ST_EMIT_FINAL : ST_IDLE;
        end
      end
      ST_EMIT_FINAL: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
          seen_d  = SEEN_NONE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        seen_d  = SEEN_NONE;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o                = '0;
    cmd_o.emit_sel       = SEL_NEW;
    cmd_o.load_in        = accept;
    cmd_o.pend_from_in   = accept && (seen_q == SEEN_ONE) && !path_last_i;
    case (state_q)
      ST_DECIDE: begin
        cmd_o.pend_from_n = stat_i.drop && !stat_i.n_last;
      end
      ST_EMIT_NEW: begin
        cmd_o.emit        = stat_i.out_free;
        cmd_o.emit_sel    = SEL_NEW;
        cmd_o.kept_from_n = stat_i.out_free;
      end
      ST_EMIT_PEND: begin
        cmd_o.emit           = stat_i.out_free;
        cmd_o.emit_sel       = SEL_PEND;
        cmd_o.kept_from_pend = stat_i.out_free;
        cmd_o.pend_from_n    = stat_i.out_free && !stat_i.n_last;
      end
      ST_EMIT_FINAL: begin
        cmd_o.emit     = stat_i.out_free;
        cmd_o.emit_sel = SEL_FINAL;
      end
      default: begin
        cmd_o.emit = 1'b0;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// ----- sv/collinear_waypoint_reducer.sv -----
// collinear_waypoint_reducer: top level, drops waypoints lying on the path within tolerance
// depends on cwr_pkg, cwr_ctrl and cwr_datapath
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   in      | in_valid_i, in_stall_o, point_x_i/y_i, path_last_i | to block
//   out     | out_valid_o, out_stall_i, out_x_o/y_o, point_valid_o, path_end_o | from block
//   cfg     | cfg_we_i, cfg_wdata_i (tolerance)              | to block
//
// a path's first point is output directly; its second too if it ends the path, else held
// later points run the multiply chain and a decide step, giving zero to two results each
// the chain has nine 25x25 and seven narrower multipliers in five register stages
// reset clears the controller, the output valid and the tolerance; no clearing pass
// a stalled output holds its result; new points are taken while it waits unless more is due
module collinear_waypoint_reducer #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cwr_pkg::TOL_BITS-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_BITS-1:0]  point_x_i,
  input  logic signed [COORD_BITS-1:0]  point_y_i,
  input  logic                          path_last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_BITS-1:0]  out_x_o,
  output logic signed [COORD_BITS-1:0]  out_y_o,
  output logic                          point_valid_o,
  output logic                          path_end_o
);
  import cwr_pkg::*;

  cwr_cmd_t  cmd;
  cwr_stat_t stat;

  // sequencing
  cwr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .path_last_i (path_last_i),
    .in_stall_o  (in_stall_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // arithmetic and point storage
  cwr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .path_last_i   (path_last_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .point_valid_o (point_valid_o),
    .path_end_o    (path_end_o)
  );

endmodule

// ----- sv/cwr_checker.sv -----
// cwr_checker: port-level assertions for the waypoint reducer, bound to the top level
// depends on collinear_waypoint_reducer
module cwr_checker #(
  parameter int unsigned COORD_BITS = 24
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          path_last_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [COORD_BITS-1:0]  out_x_o,
  input logic signed [COORD_BITS-1:0]  out_y_o,
  input logic                          point_valid_o,
  input logic                          path_end_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_x_o) && $stable(out_y_o)
      && $stable(point_valid_o) && $stable(path_end_o))
    else $error("stalled result changed");

  // an end-only result closes the path and carries zero coordinates
  a_end_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !point_valid_o |-> path_end_o && (out_x_o == '0) && (out_y_o == '0))
    else $error("malformed end-only result");

  // no new result appears in the cycle after an input transfer is taken
  a_no_direct_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !(out_valid_o && !$past(out_valid_o)))
    else $error("result appeared without processing cycle");

  // the block is busy in the cycle after it takes the final point of a path
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && path_last_i |=> in_stall_o)
    else $error("input not stalled after final point");

endmodule

bind collinear_waypoint_reducer cwr_checker #(
  .COORD_BITS (COORD_BITS)
) u_cwr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .path_last_i   (path_last_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_x_o       (out_x_o),
  .out_y_o       (out_y_o),
  .point_valid_o (point_valid_o),
  .path_end_o    (path_end_o)
);

// ----- tb/tb_collinear_waypoint_reducer.sv -----
// tb_collinear_waypoint_reducer: self-checking testbench for the collinear waypoint reducer
// predicts kept waypoints with exact wide integer arithmetic and scores every output transfer
// depends on cwr_pkg and collinear_waypoint_reducer
`timescale 1ns / 100ps

module tb_collinear_waypoint_reducer;

  localparam int COORD_W      = 24;
  localparam int TOL_W        = cwr_pkg::TOL_BITS;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES  = 300;
  localparam logic [TOL_W-1:0] TOL_MAX = {TOL_W{1'b1}};

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [127:0] wide_t;

  // one output transfer as the block should present it
  typedef struct {
    coord_t x;
    coord_t y;
    logic   has_point;
    logic   path_end;
  } waypoint_result_t;

  // predicts reduced paths and holds the waypoints still owed by the block
  class waypoint_scoreboard;
    logic [TOL_W-1:0] tolerance = '0;
    coord_t kept_x = '0, kept_y = '0;
    coord_t pend_x = '0, pend_y = '0;
    int points_seen = 0;
    waypoint_result_t owed_q[$];
    int errors = 0;
    int results_checked = 0;
    int points_dropped = 0;
    int end_only = 0;

    function void set_tolerance(input logic [TOL_W-1:0] v);
      tolerance = v;
    endfunction

    function int outstanding();
      return owed_q.size();
    endfunction

    // pending point lies on the segment kept -> next, within tolerance
    function bit on_segment(input coord_t nx, input coord_t ny);
      wide_t sx, sy, rx, ry, a, b, tol, len2, proj, cross_v;
      a = nx; b = kept_x; sx = a - b;
      a = ny; b = kept_y; sy = a - b;
      a = pend_x; b = kept_x; rx = a - b;
      a = pend_y; b = kept_y; ry = a - b;
      tol = tolerance;
      if (sx == 0 && sy == 0) begin
        return (rx * rx + ry * ry) <= tol * tol;
      end
      len2 = sx * sx + sy * sy;
      proj = rx * sx + ry * sy;
      if (proj < 0 || proj > len2) begin
        return 1'b0;
      end
      cross_v = rx * sy - ry * sx;
      return (cross_v * cross_v) <= (tol * tol * len2);
    endfunction

    function void owe(input coord_t x, input coord_t y, input logic has_pt, input logic pe);
      waypoint_result_t r;
      r.x = x;
      r.y = y;
      r.has_point = has_pt;
      r.path_end = pe;
      owed_q.insert(owed_q.size(), r);
    endfunction

    // accepted input transfer: advance the path state and note what comes out
    function void note_point(input coord_t x, input coord_t y, input logic last);
      if (points_seen == 0) begin
        owe(x, y, 1'b1, last);
        kept_x = x;
        kept_y = y;
        points_seen = last ? 0 : 1;
        return;
      end
      if (points_seen == 1) begin
        if (last) begin
          owe(x, y, 1'b1, 1'b1);
          points_seen = 0;
        end else begin
          pend_x = x;
          pend_y = y;
          points_seen = 2;
        end
        return;
      end
      if (on_segment(x, y)) begin
        points_dropped++;
      end else begin
        owe(pend_x, pend_y, 1'b1, 1'b0);
        kept_x = pend_x;
        kept_y = pend_y;
      end
      if (last) begin
        if (x != kept_x || y != kept_y) begin
          owe(x, y, 1'b1, 1'b1);
        end else begin
          owe('0, '0, 1'b0, 1'b1);
          end_only++;
        end
        points_seen = 0;
      end else begin
        pend_x = x;
        pend_y = y;
      end
    endfunction

    // accepted output transfer against the oldest owed waypoint
    function void check_result(input coord_t x, input coord_t y, input logic has_pt,
                               input logic pe);
      waypoint_result_t r;
      results_checked++;
      if (owed_q.size() == 0) begin
        $error("unexpected result: x %0d y %0d point_valid %b path_end %b", x, y, has_pt, pe);
        errors++;
        return;
      end
      r = owed_q.pop_front();
      if (x !== r.x) begin
        $error("out_x: expected %0d, got %0d", r.x, x);
        errors++;
      end
      if (y !== r.y) begin
        $error("out_y: expected %0d, got %0d", r.y, y);
        errors++;
      end
      if (has_pt !== r.has_point) begin
        $error("point_valid: expected %b, got %b", r.has_point, has_pt);
        errors++;
      end
      if (pe !== r.path_end) begin
        $error("path_end: expected %b, got %b", r.path_end, pe);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [TOL_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  coord_t           point_x_i = '0;
  coord_t           point_y_i = '0;
  logic             path_last_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  coord_t           out_x_o;
  coord_t           out_y_o;
  logic             point_valid_o;
  logic             path_end_o;

  waypoint_scoreboard sb = new();
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  logic             hold_req = 1'b0;
  logic [TOL_W-1:0] tol_now = '0;
  int               points_sent = 0;
  int               tol_writes = 0;

  collinear_waypoint_reducer #(
    .COORD_BITS(COORD_W)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .path_last_i  (path_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .point_valid_o(point_valid_o),
    .path_end_o   (path_end_o)
  );

  // 8 ns clock
  always #4 clk_i = ~clk_i;

  // one input transfer, after a random idle gap
  task automatic send_point(input coord_t x, input coord_t y, input logic last);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    point_x_i   <= x;
    point_y_i   <= y;
    path_last_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_point(x, y, last);
    points_sent++;
  endtask

  // a path along a line with optional lateral jitter, repeats and backtracks
  task automatic send_track();
    int n, span, jit, i, k, lx, ly, dx, dy, jx, jy;
    n = $urandom_range(1, 8);
    if ($urandom_range(0, 9) == 0) n = $urandom_range(9, 20);
    case ($urandom_range(0, 2))
      0:       span = 64;
      1:       span = 1 << 16;
      default: span = 1 << 22;
    endcase
    case ($urandom_range(0, 3))
      0:       jit = 0;
      1:       jit = 2;
      2:       jit = (tol_now < span) ? int'(tol_now) : span;
      default: jit = span / 8;
    endcase
    lx = int'($urandom_range(0, 2 * span)) - span;
    ly = int'($urandom_range(0, 2 * span)) - span;
    dx = int'($urandom_range(0, span / 2)) - span / 4;
    dy = int'($urandom_range(0, span / 2)) - span / 4;
    for (i = 0; i < n; i++) begin
      k = ($urandom_range(0, 7) == 0) ? -1 : int'($urandom_range(0, 3));
      if (i > 0) begin
        lx += k * dx;
        ly += k * dy;
      end
      jx = 0;
      jy = 0;
      if (jit > 0 && $urandom_range(0, 1) == 1) begin
        jx = int'($urandom_range(0, 2 * jit)) - jit;
        jy = int'($urandom_range(0, 2 * jit)) - jit;
      end
      send_point(coord_t'(lx + jx), coord_t'(ly + jy), i == n - 1);
    end
  endtask

  // mostly well-formed paths, some loose points with random end markers
  task automatic send_items(input int n);
    int first;
    first = points_sent;
    while (points_sent - first < n) begin
      if ($urandom_range(0, 4) == 0) begin
        send_point(coord_t'($urandom), coord_t'($urandom), $urandom_range(0, 3) == 0);
      end else begin
        send_track();
      end
    end
  endtask

  // wait for the last owed waypoint, then for any silent work to finish
  task automatic settle();
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] v);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_tolerance(v);
    tol_now = v;
    tol_writes++;
  endtask

  function automatic logic [TOL_W-1:0] pick_tolerance(input int p);
    case (p % 4)
      0:       return TOL_MAX;
      1:       return '0;
      2:       return TOL_W'($urandom_range(1, 63));
      default: return TOL_W'($urandom) >> $urandom_range(0, TOL_W - 1);
    endcase
  endfunction

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // corner paths at zero tolerance
  task automatic run_directed();
    // single point at the coordinate extremes
    send_point(-24'sd8388608, 24'sd8388607, 1'b1);
    // two equal points pass unchanged
    send_point(24'sd8388607, -24'sd8388608, 1'b0);
    send_point(24'sd8388607, -24'sd8388608, 1'b1);
    // exact collinear middle point dropped, then a corner kept
    send_point(24'sd0, 24'sd0, 1'b0);
    send_point(24'sd5, 24'sd5, 1'b0);
    send_point(24'sd10, 24'sd10, 1'b0);
    send_point(-24'sd3, 24'sd4, 1'b1);
    // final point equal to kept point: end-only transfer
    send_point(24'sd7, 24'sd7, 1'b0);
    send_point(24'sd7, 24'sd7, 1'b0);
    send_point(24'sd7, 24'sd7, 1'b1);
    // zero-length segment, pending point off it: two results at once
    send_point(24'sd1, 24'sd1, 1'b0);
    send_point(24'sd4, 24'sd5, 1'b0);
    send_point(24'sd1, 24'sd1, 1'b1);
    // projection behind the kept point
    send_point(24'sd0, 24'sd0, 1'b0);
    send_point(-24'sd1, 24'sd0, 1'b0);
    send_point(24'sd10, 24'sd0, 1'b1);
    // projection past the next point
    send_point(24'sd0, 24'sd0, 1'b0);
    send_point(24'sd20, 24'sd0, 1'b0);
    send_point(24'sd10, 24'sd0, 1'b1);
    // full-range diagonal, middle dropped
    send_point(-24'sd8388608, -24'sd8388608, 1'b0);
    send_point(24'sd0, 24'sd0, 1'b0);
    send_point(24'sd8388607, 24'sd8388607, 1'b1);
    // left open so the next tolerance applies mid-path
    send_point(24'sd0, 24'sd0, 1'b0);
    send_point(24'sd2, 24'sd1, 1'b0);
  endtask

  // output side: score accepted transfers, stall at random or for a long hold-off
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        sb.check_result(out_x_o, out_y_o, point_valid_o, path_end_o);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    int p;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_idling(9, 81);
    run_directed();
    in_valid_i <= 1'b0;
    settle();
    for (p = 0; p < 12; p++) begin
      if (p == 4) set_idling(81, 9);
      if (p == 8) begin
        // receiver holds off while the sender keeps offering points
        set_idling(0, 0);
        hold_req = 1'b1;
        send_items(40);
        in_valid_i <= 1'b0;
        settle();
      end
      write_tolerance(pick_tolerance(p));
      send_items(140);
      in_valid_i <= 1'b0;
      settle();
    end
    $display("%0d waypoints sent over %0d tolerance settings, %0d results checked",
             points_sent, tol_writes, sb.results_checked);
    $display("%0d points dropped as collinear, %0d end-only transfers",
             sb.points_dropped, sb.end_only);
    if (sb.errors == 0) begin
      $display("tb_collinear_waypoint_reducer: clean");
    end else begin
      $display("tb_collinear_waypoint_reducer: errors");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #(8_000_000);
    $display("tb_collinear_waypoint_reducer: errors");
    $finish;
  end

endmodule
